[hdl/srfg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srfg_pkg
// Shared types and constants for the speed ramp frame generator.
// ----------------------------------------------------------------------------
package srfg_pkg;

	localparam int SPEED_W = 13;
	localparam int STEP_W  = 10;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 4;
	localparam int ADDR_W  = 1;
	localparam int DATA_W  = 13;

	// register indexes
	localparam logic [ADDR_W-1:0] REG_RAMP_STEP   = 1'd0;
	localparam logic [ADDR_W-1:0] REG_ENGAGE_JUMP = 1'd1;

	localparam logic [STEP_W-1:0]  RAMP_STEP_RST   = 10'd76;
	localparam logic [SPEED_W-1:0] ENGAGE_JUMP_RST = 13'd250;

	// frame byte values
	localparam logic [BYTE_W-1:0] B_SOF       = 8'h68;
	localparam logic [BYTE_W-1:0] B_CMD       = 8'h08;
	localparam logic [BYTE_W-1:0] B_ST_IDLE   = 8'h20;
	localparam logic [BYTE_W-1:0] B_ST_HOLD   = 8'h21;
	localparam logic [BYTE_W-1:0] B_FLAG_OFF  = 8'h00;
	localparam logic [BYTE_W-1:0] B_FLAG_ON   = 8'h50;
	localparam logic [BYTE_W-1:0] B_PAD       = 8'h00;
	localparam logic [BYTE_W-1:0] B_LEN       = 8'h14;
	localparam logic [BYTE_W-1:0] B_EOF       = 8'h43;
	localparam logic [BYTE_W-1:0] B_CHK_BASE  = B_CMD + B_PAD + B_LEN;

	// frame byte positions
	localparam logic [IDX_W-1:0] P_SOF   = 4'd0;
	localparam logic [IDX_W-1:0] P_CMD   = 4'd1;
	localparam logic [IDX_W-1:0] P_STATE = 4'd2;
	localparam logic [IDX_W-1:0] P_FLAG  = 4'd3;
	localparam logic [IDX_W-1:0] P_HI    = 4'd4;
	localparam logic [IDX_W-1:0] P_LO    = 4'd5;
	localparam logic [IDX_W-1:0] P_PAD   = 4'd6;
	localparam logic [IDX_W-1:0] P_LEN   = 4'd7;
	localparam logic [IDX_W-1:0] P_CHK   = 4'd8;
	localparam logic [IDX_W-1:0] P_EOF   = 4'd9;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [BYTE_W-1:0]  state_b;
		logic [BYTE_W-1:0]  flag_b;
		logic [BYTE_W-1:0]  chk;
	} frame_t;

endpackage
`default_nettype wire

[hdl/srfg_ramp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srfg_ramp
// Config registers, speed state and one-item frame field register.
// ----------------------------------------------------------------------------
module srfg_ramp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [srfg_pkg::ADDR_W-1:0]   cfg_addr,
	input  wire logic [srfg_pkg::DATA_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [srfg_pkg::SPEED_W-1:0]  target,
	output logic                               frm_valid,
	input  wire logic                          frm_take,
	output srfg_pkg::frame_t                   frm
);

	logic [srfg_pkg::STEP_W-1:0]  ramp_step_q;
	logic [srfg_pkg::SPEED_W-1:0] engage_jump_q;
	logic [srfg_pkg::SPEED_W-1:0] speed_q;
	logic                         valid_s1;
	srfg_pkg::frame_t             frame_s1;

	logic [srfg_pkg::SPEED_W:0]   up_sum;
	logic [srfg_pkg::SPEED_W-1:0] up_next;
	logic [srfg_pkg::SPEED_W-1:0] step_ext;
	logic [srfg_pkg::SPEED_W-1:0] nxt;
	logic                         accept;
	srfg_pkg::frame_t             frame_d;

	assign step_ext = {{(srfg_pkg::SPEED_W-srfg_pkg::STEP_W){1'b0}}, ramp_step_q};
	assign up_sum   = (speed_q == '0) ? {1'b0, engage_jump_q}
	                                  : {1'b0, speed_q} + {1'b0, step_ext};
	assign up_next  = (up_sum > {1'b0, target}) ? target
	                                            : up_sum[srfg_pkg::SPEED_W-1:0];

	always_comb begin
		if (speed_q < target) begin
			nxt = up_next;
		end else if (speed_q > target) begin
			nxt = (speed_q > step_ext) ? speed_q - step_ext : '0;
		end else begin
			nxt = speed_q;
		end
		frame_d.speed   = nxt;
		frame_d.state_b = (nxt != '0 && nxt == target) ? srfg_pkg::B_ST_HOLD
		                                               : srfg_pkg::B_ST_IDLE;
		frame_d.flag_b  = (nxt != '0 || target != '0) ? srfg_pkg::B_FLAG_ON
		                                              : srfg_pkg::B_FLAG_OFF;
		frame_d.chk     = srfg_pkg::B_CHK_BASE + frame_d.state_b + frame_d.flag_b
		                + {3'b000, nxt[srfg_pkg::SPEED_W-1:8]} + nxt[7:0];
	end

	assign in_ready  = !valid_s1 || frm_take;
	assign accept    = in_valid && in_ready;
	assign frm_valid = valid_s1;
	assign frm       = frame_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q   <= srfg_pkg::RAMP_STEP_RST;
			engage_jump_q <= srfg_pkg::ENGAGE_JUMP_RST;
			speed_q       <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					srfg_pkg::REG_RAMP_STEP:   ramp_step_q   <= cfg_data[srfg_pkg::STEP_W-1:0];
					srfg_pkg::REG_ENGAGE_JUMP: engage_jump_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				speed_q  <= nxt;
				valid_s1 <= 1'b1;
			end else if (frm_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frame_d;
		end
	end

endmodule
`default_nettype wire

[hdl/srfg_serializer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srfg_serializer
// Sends one held frame as ten output items, one per accepted cycle.
// ----------------------------------------------------------------------------
module srfg_serializer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          frm_valid,
	output logic                               frm_take,
	input  wire srfg_pkg::frame_t              frm,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [srfg_pkg::BYTE_W-1:0]        out_byte,
	output logic                               out_last,
	output logic [srfg_pkg::SPEED_W-1:0]       out_speed
);

	logic                         busy_q;
	logic [srfg_pkg::IDX_W-1:0]   idx_q;
	srfg_pkg::frame_t             cur_q;
	logic                         done;

	assign out_valid = busy_q;
	assign out_last  = (idx_q == srfg_pkg::P_EOF);
	assign out_speed = cur_q.speed;
	assign done      = busy_q && out_ready && out_last;
	assign frm_take  = frm_valid && (!busy_q || done);

	always_comb begin
		unique case (idx_q)
			srfg_pkg::P_SOF:   out_byte = srfg_pkg::B_SOF;
			srfg_pkg::P_CMD:   out_byte = srfg_pkg::B_CMD;
			srfg_pkg::P_STATE: out_byte = cur_q.state_b;
			srfg_pkg::P_FLAG:  out_byte = cur_q.flag_b;
			srfg_pkg::P_HI:    out_byte = {3'b000, cur_q.speed[srfg_pkg::SPEED_W-1:8]};
			srfg_pkg::P_LO:    out_byte = cur_q.speed[7:0];
			srfg_pkg::P_PAD:   out_byte = srfg_pkg::B_PAD;
			srfg_pkg::P_LEN:   out_byte = srfg_pkg::B_LEN;
			srfg_pkg::P_CHK:   out_byte = cur_q.chk;
			srfg_pkg::P_EOF:   out_byte = srfg_pkg::B_EOF;
			default:           out_byte = srfg_pkg::B_PAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= srfg_pkg::P_SOF;
		end else begin
			if (frm_take) begin
				busy_q <= 1'b1;
				idx_q  <= srfg_pkg::P_SOF;
			end else if (done) begin
				busy_q <= 1'b0;
				idx_q  <= srfg_pkg::P_SOF;
			end else if (busy_q && out_ready) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frm_take) begin
			cur_q <= frm;
		end
	end

endmodule
`default_nettype wire

[hdl/speed_ramp_frame_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// speed_ramp_frame_generator
// Slew-rate limited speed, one ten-byte command frame per input tick.
//
// channel  dir  fields (lsb first)
// s_axis   in   tdata: target_speed[12:0]
// m_axis   out  tdata: frame_byte[7:0], current_speed_out[20:8]; tlast: last_byte
// cfg      in   0: ramp_step[9:0], 1: engage_jump[12:0]
//
// Each tick yields ten output items from the byte serializer, one per
// cycle when tready is high. One tick is buffered in the ramp register
// while the previous frame drains. Reset stops the speed and loads
// ramp_step 76, engage_jump 250. Output stalls hold the item in place.
// ----------------------------------------------------------------------------
module speed_ramp_frame_generator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_addr,
	input  wire logic [12:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [15:0]  s_axis_tdata,   // target_speed[12:0]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [23:0]       m_axis_tdata,   // frame_byte[7:0], current_speed_out[20:8]
	output logic              m_axis_tlast
);

	logic                                frm_valid;
	logic                                frm_take;
	srfg_pkg::frame_t                    frm;
	logic [srfg_pkg::BYTE_W-1:0]         out_byte;
	logic [srfg_pkg::SPEED_W-1:0]        out_speed;

	srfg_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.target    (s_axis_tdata[12:0]),
		.frm_valid (frm_valid),
		.frm_take  (frm_take),
		.frm       (frm)
	);

	srfg_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm_valid (frm_valid),
		.frm_take  (frm_take),
		.frm       (frm),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (out_byte),
		.out_last  (m_axis_tlast),
		.out_speed (out_speed)
	);

	assign m_axis_tdata = {3'b000, out_speed, out_byte};

endmodule
`default_nettype wire
